[design/pbd_pkg.sv]
// Shared types and constants for the point-to-box squared distance pipeline.
// No dependencies; every other design file imports this package.
package pbd_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int MAG_WIDTH   = COORD_WIDTH;
    localparam int SQ_WIDTH    = 2 * MAG_WIDTH;
    localparam int DIST_WIDTH  = 2 * COORD_WIDTH + 2;
    localparam int CFG_IDX_WIDTH = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic        [MAG_WIDTH-1:0]   mag_t;
    typedef logic        [SQ_WIDTH-1:0]    sq_t;
    typedef logic        [DIST_WIDTH-1:0]  dist_t;
    typedef logic        [CFG_IDX_WIDTH-1:0] cfg_idx_t;

    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

    // Configuration register indexes
    localparam cfg_idx_t CFG_OUTER_X_MIN = 3'd0;
    localparam cfg_idx_t CFG_OUTER_X_MAX = 3'd1;
    localparam cfg_idx_t CFG_OUTER_Y_MIN = 3'd2;
    localparam cfg_idx_t CFG_OUTER_Y_MAX = 3'd3;
    localparam cfg_idx_t CFG_OUTER_Z_MIN = 3'd4;
    localparam cfg_idx_t CFG_OUTER_Z_MAX = 3'd5;

    typedef struct packed {
        coord_t px;
        coord_t py;
        coord_t pz;
        coord_t box_x_min;
        coord_t box_x_max;
        coord_t box_y_min;
        coord_t box_y_max;
        coord_t box_z_min;
        coord_t box_z_max;
        logic   inner_only;
    } pbd_in_t;

    typedef struct packed {
        dist_t  dist_sq;
        coord_t near_x;
        coord_t near_y;
        coord_t near_z;
        logic   no_inner_face;
    } pbd_out_t;

    typedef struct packed {
        coord_t x_min;
        coord_t x_max;
        coord_t y_min;
        coord_t y_max;
        coord_t z_min;
        coord_t z_max;
    } pbd_box_t;

    // Per-axis offsets to the chosen boundary point
    typedef struct packed {
        diff_t  diff_x;
        diff_t  diff_y;
        diff_t  diff_z;
        coord_t near_x;
        coord_t near_y;
        coord_t near_z;
        logic   no_inner_face;
    } pbd_sel_t;

    typedef struct packed {
        sq_t    sq_x;
        sq_t    sq_y;
        sq_t    sq_z;
        coord_t near_x;
        coord_t near_y;
        coord_t near_z;
        logic   no_inner_face;
    } pbd_sq_t;

endpackage

[design/pbd_select.sv]
// Boundary point selection: clamps outside points, picks the nearest eligible
// face for inside points. Combinational; uses pbd_pkg.
module pbd_select (
    input  pbd_pkg::pbd_in_t  item,
    input  pbd_pkg::pbd_box_t outer,
    output pbd_pkg::pbd_sel_t sel
);
    import pbd_pkg::*;

    localparam logic [2:0] FACE_X_MIN = 3'd0;
    localparam logic [2:0] FACE_X_MAX = 3'd1;
    localparam logic [2:0] FACE_Y_MIN = 3'd2;
    localparam logic [2:0] FACE_Y_MAX = 3'd3;
    localparam logic [2:0] FACE_Z_MIN = 3'd4;
    localparam logic [2:0] FACE_Z_MAX = 3'd5;

    typedef struct packed {
        logic       valid;
        mag_t       gap;
        logic [2:0] face;
    } cand_t;

    // Earlier candidate wins ties; b must be the later face.
    function automatic cand_t pick(input cand_t a, input cand_t b);
        cand_t r;
        if (b.valid && (!a.valid || (b.gap < a.gap))) begin
            r = b;
        end else begin
            r = a;
        end
        return r;
    endfunction

    coord_t     p     [3];
    coord_t     lo    [3];
    coord_t     hi    [3];
    coord_t     olo   [3];
    coord_t     ohi   [3];
    coord_t     clamp [3];
    diff_t      odiff [3];
    diff_t      dlo   [3];
    diff_t      dhi   [3];
    logic [2:0] in_range;
    cand_t      cand  [6];
    cand_t      pair  [3];
    cand_t      best01;
    cand_t      best;
    diff_t      rdiff [3];
    coord_t     rnear [3];
    logic       noface;
    logic [1:0] best_ax;

    always_comb begin
        p[0] = item.px;         p[1] = item.py;         p[2] = item.pz;
        lo[0] = item.box_x_min; lo[1] = item.box_y_min; lo[2] = item.box_z_min;
        hi[0] = item.box_x_max; hi[1] = item.box_y_max; hi[2] = item.box_z_max;
        olo[0] = outer.x_min;   olo[1] = outer.y_min;   olo[2] = outer.z_min;
        ohi[0] = outer.x_max;   ohi[1] = outer.y_max;   ohi[2] = outer.z_max;

        for (int i = 0; i < 3; i++) begin
            in_range[i] = !(p[i] < lo[i]) && !(p[i] > hi[i]);
            if (p[i] < lo[i]) begin
                clamp[i] = lo[i];
            end else if (p[i] > hi[i]) begin
                clamp[i] = hi[i];
            end else begin
                clamp[i] = p[i];
            end
            odiff[i] = diff_t'(p[i]) - diff_t'(clamp[i]);
            // Both are non-negative once the point is inside on this axis
            dlo[i] = diff_t'(p[i]) - diff_t'(lo[i]);
            dhi[i] = diff_t'(hi[i]) - diff_t'(p[i]);
            cand[2*i].valid   = !item.inner_only || (lo[i] != olo[i]);
            cand[2*i].gap     = dlo[i][MAG_WIDTH-1:0];
            cand[2*i+1].valid = !item.inner_only || (hi[i] != ohi[i]);
            cand[2*i+1].gap   = dhi[i][MAG_WIDTH-1:0];
        end
        cand[0].face = FACE_X_MIN;
        cand[1].face = FACE_X_MAX;
        cand[2].face = FACE_Y_MIN;
        cand[3].face = FACE_Y_MAX;
        cand[4].face = FACE_Z_MIN;
        cand[5].face = FACE_Z_MAX;

        for (int i = 0; i < 3; i++) begin
            pair[i] = pick(cand[2*i], cand[2*i+1]);
        end
        best01  = pick(pair[0], pair[1]);
        best    = pick(best01, pair[2]);
        best_ax = best.face[2:1];

        noface = 1'b0;
        for (int i = 0; i < 3; i++) begin
            rdiff[i] = odiff[i];
            rnear[i] = clamp[i];
        end
        if (&in_range) begin
            for (int i = 0; i < 3; i++) begin
                rdiff[i] = '0;
                rnear[i] = p[i];
            end
            if (best.valid) begin
                // Sign does not matter: only the square is used
                rdiff[best_ax] = diff_t'(best.gap);
                rnear[best_ax] = best.face[0] ? hi[best_ax] : lo[best_ax];
            end else begin
                // No eligible face: snap to the x lower bound
                noface   = 1'b1;
                rnear[0] = lo[0];
            end
        end

        sel.diff_x        = rdiff[0];
        sel.diff_y        = rdiff[1];
        sel.diff_z        = rdiff[2];
        sel.near_x        = rnear[0];
        sel.near_y        = rnear[1];
        sel.near_z        = rnear[2];
        sel.no_inner_face = noface;
    end

endmodule

[design/pbd_square.sv]
// Per-axis squaring of the offsets to the boundary point: three independent
// multipliers. Combinational; uses pbd_pkg.
module pbd_square (
    input  pbd_pkg::pbd_sel_t sel,
    output pbd_pkg::pbd_sq_t  sqr
);
    import pbd_pkg::*;

    diff_t d   [3];
    diff_t neg [3];
    mag_t  mag [3];
    sq_t   s   [3];

    always_comb begin
        d[0] = sel.diff_x;
        d[1] = sel.diff_y;
        d[2] = sel.diff_z;
        for (int i = 0; i < 3; i++) begin
            neg[i] = -d[i];
            // Offsets stay within one less than 2^COORD_WIDTH in magnitude
            mag[i] = d[i][DIFF_WIDTH-1] ? neg[i][MAG_WIDTH-1:0] : d[i][MAG_WIDTH-1:0];
            s[i]   = sq_t'(mag[i]) * sq_t'(mag[i]);
        end
        sqr.sq_x          = s[0];
        sqr.sq_y          = s[1];
        sqr.sq_z          = s[2];
        sqr.near_x        = sel.near_x;
        sqr.near_y        = sel.near_y;
        sqr.near_z        = sel.near_z;
        sqr.no_inner_face = sel.no_inner_face;
    end

endmodule

[design/point_box_distance_squared.sv]
// Squared distance from a 3D point to the boundary of an axis-aligned box,
// with the nearest boundary point. Takes one word per cycle while the output
// is not stalled and returns one result word per input word, in order, four
// register stages after the input: input register, selection register,
// square register, result register. Each stage moves as soon as the one
// after it is free, so a stalled output only stops intake once every stage
// holds a word. The user must write the outer bounds on the configuration
// port only while no word is in flight; the block itself does not enforce
// this. cfg_ready is always high and indexes past the last register are
// dropped. Depends on pbd_pkg, pbd_select and pbd_square.
module point_box_distance_squared (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pbd_pkg::pbd_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pbd_pkg::pbd_out_t  m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  pbd_pkg::cfg_idx_t  cfg_index,
    input  pbd_pkg::coord_t    cfg_data
);
    import pbd_pkg::*;

    pbd_box_t outer_reg;

    logic     in_valid_reg;
    pbd_in_t  in_reg;
    logic     sel_valid_reg;
    pbd_sel_t sel_reg;
    logic     sq_valid_reg;
    pbd_sq_t  sq_reg;
    logic     out_valid_reg;
    pbd_out_t out_reg;

    pbd_sel_t sel_next;
    pbd_sq_t  sq_next;
    dist_t    dist_next;

    logic rdy_in, rdy_sel, rdy_sq, rdy_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outer_reg.x_min <= COORD_MIN;
            outer_reg.x_max <= COORD_MAX;
            outer_reg.y_min <= COORD_MIN;
            outer_reg.y_max <= COORD_MAX;
            outer_reg.z_min <= COORD_MIN;
            outer_reg.z_max <= COORD_MAX;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_OUTER_X_MIN: outer_reg.x_min <= cfg_data;
                CFG_OUTER_X_MAX: outer_reg.x_max <= cfg_data;
                CFG_OUTER_Y_MIN: outer_reg.y_min <= cfg_data;
                CFG_OUTER_Y_MAX: outer_reg.y_max <= cfg_data;
                CFG_OUTER_Z_MIN: outer_reg.z_min <= cfg_data;
                CFG_OUTER_Z_MAX: outer_reg.z_max <= cfg_data;
                default: ;
            endcase
        end
    end

    // A stage takes a word when it is empty or its word moves on
    assign rdy_out = !out_valid_reg || m_ready;
    assign rdy_sq  = !sq_valid_reg  || rdy_out;
    assign rdy_sel = !sel_valid_reg || rdy_sq;
    assign rdy_in  = !in_valid_reg  || rdy_sel;
    assign s_ready = rdy_in;

    pbd_select u_select (
        .item  (in_reg),
        .outer (outer_reg),
        .sel   (sel_next)
    );

    pbd_square u_square (
        .sel (sel_reg),
        .sqr (sq_next)
    );

    assign dist_next = dist_t'(sq_reg.sq_x) + dist_t'(sq_reg.sq_y) + dist_t'(sq_reg.sq_z);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            sel_valid_reg <= 1'b0;
            sq_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rdy_in) begin
                in_valid_reg <= s_valid;
            end
            if (rdy_sel) begin
                sel_valid_reg <= in_valid_reg;
            end
            if (rdy_sq) begin
                sq_valid_reg <= sel_valid_reg;
            end
            if (rdy_out) begin
                out_valid_reg <= sq_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && rdy_in) begin
            in_reg <= s_data;
        end
        if (in_valid_reg && rdy_sel) begin
            sel_reg <= sel_next;
        end
        if (sel_valid_reg && rdy_sq) begin
            sq_reg <= sq_next;
        end
        if (sq_valid_reg && rdy_out) begin
            out_reg.dist_sq       <= dist_next;
            out_reg.near_x        <= sq_reg.near_x;
            out_reg.near_y        <= sq_reg.near_y;
            out_reg.near_z        <= sq_reg.near_z;
            out_reg.no_inner_face <= sq_reg.no_inner_face;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

[sim/point_box_distance_squared_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for point_box_distance_squared: watches the query, result and
// outer-bound channels, predicts every result and compares it field by field.
// Depends on pbd_pkg.
module point_box_distance_squared_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  pbd_pkg::pbd_in_t   s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  pbd_pkg::pbd_out_t  m_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  pbd_pkg::cfg_idx_t  cfg_index,
    input  pbd_pkg::coord_t    cfg_data,
    output int                 mismatches,
    output int                 awaited,
    output int                 checked
);
    import pbd_pkg::*;

    pbd_box_t outer_bounds;
    pbd_out_t nearest_q[$];
    pbd_out_t want;
    bit       bad;

    function automatic pbd_out_t nearest_boundary(pbd_in_t w, pbd_box_t ob);
        longint      pt[3], lo[3], hi[3], olo[3], ohi[3], q[3];
        longint      d, best_d;
        int          a, s, best_ax, best_side;
        bit          found, all_in, eligible;
        logic [63:0] acc;
        pbd_out_t    r;
        pt[0] = w.px;         pt[1] = w.py;         pt[2] = w.pz;
        lo[0] = w.box_x_min;  lo[1] = w.box_y_min;  lo[2] = w.box_z_min;
        hi[0] = w.box_x_max;  hi[1] = w.box_y_max;  hi[2] = w.box_z_max;
        olo[0] = ob.x_min;    olo[1] = ob.y_min;    olo[2] = ob.z_min;
        ohi[0] = ob.x_max;    ohi[1] = ob.y_max;    ohi[2] = ob.z_max;
        all_in = 1'b1;
        for (a = 0; a < 3; a++) begin
            q[a] = pt[a];
            if (pt[a] < lo[a] || pt[a] > hi[a])
                all_in = 1'b0;
        end
        r.no_inner_face = 1'b0;
        acc = '0;
        if (all_in) begin
            // Scan faces xmin, xmax, ymin, ... ; strict compare keeps the earlier face on ties
            found = 1'b0;
            best_d = 0;
            best_ax = 0;
            best_side = 0;
            for (a = 0; a < 3; a++) begin
                for (s = 0; s < 2; s++) begin
                    d = s ? hi[a] - pt[a] : pt[a] - lo[a];
                    eligible = !w.inner_only || (s ? hi[a] != ohi[a] : lo[a] != olo[a]);
                    if (eligible && (!found || d < best_d)) begin
                        found = 1'b1;
                        best_d = d;
                        best_ax = a;
                        best_side = s;
                    end
                end
            end
            if (!found) begin
                r.no_inner_face = 1'b1;
                q[0] = lo[0];
            end else begin
                q[best_ax] = best_side ? hi[best_ax] : lo[best_ax];
                acc = best_d * best_d;
            end
        end else begin
            // Clamp each out-of-range axis; below min wins on an inverted axis
            for (a = 0; a < 3; a++) begin
                if (pt[a] < lo[a])
                    q[a] = lo[a];
                else if (pt[a] > hi[a])
                    q[a] = hi[a];
                acc = acc + (pt[a] - q[a]) * (pt[a] - q[a]);
            end
        end
        r.dist_sq = dist_t'(acc);
        r.near_x = coord_t'(q[0]);
        r.near_y = coord_t'(q[1]);
        r.near_z = coord_t'(q[2]);
        return r;
    endfunction

    function automatic bit field_bad(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            outer_bounds <= '{x_min: COORD_MIN, x_max: COORD_MAX, y_min: COORD_MIN,
                              y_max: COORD_MAX, z_min: COORD_MIN, z_max: COORD_MAX};
            nearest_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_OUTER_X_MIN: outer_bounds.x_min <= cfg_data;
                    CFG_OUTER_X_MAX: outer_bounds.x_max <= cfg_data;
                    CFG_OUTER_Y_MIN: outer_bounds.y_min <= cfg_data;
                    CFG_OUTER_Y_MAX: outer_bounds.y_max <= cfg_data;
                    CFG_OUTER_Z_MIN: outer_bounds.z_min <= cfg_data;
                    CFG_OUTER_Z_MAX: outer_bounds.z_max <= cfg_data;
                    default: ;
                endcase
            end
            // Compare before queuing so a word never meets its own prediction
            if (m_valid && m_ready) begin
                if (nearest_q.size() == 0) begin
                    $display("%0t: unexpected result word, dist_sq 0x%0h near (%0d, %0d, %0d)",
                             $time, m_data.dist_sq, m_data.near_x, m_data.near_y,
                             m_data.near_z);
                    mismatches++;
                end else begin
                    want = nearest_q.pop_front();
                    bad = field_bad("dist_sq", want.dist_sq, m_data.dist_sq);
                    bad |= field_bad("near_x", want.near_x, m_data.near_x);
                    bad |= field_bad("near_y", want.near_y, m_data.near_y);
                    bad |= field_bad("near_z", want.near_z, m_data.near_z);
                    bad |= field_bad("no_inner_face", want.no_inner_face,
                                     m_data.no_inner_face);
                    if (bad)
                        mismatches++;
                    checked++;
                end
            end
            if (s_valid && s_ready)
                nearest_q.push_back(nearest_boundary(s_data, outer_bounds));
        end
        awaited = nearest_q.size();
    end

endmodule

[sim/point_box_distance_squared_tb.sv]
`timescale 1ns / 100ps
// Testbench top for point_box_distance_squared: drives query words and outer
// bound writes under random handshake pressure and prints the verdict.
// Depends on pbd_pkg, point_box_distance_squared and its checker.
module point_box_distance_squared_tb;
    import pbd_pkg::*;

    localparam int       CYCLE_LIMIT       = 400000;
    localparam int       WORDS_PER_SETTING = 175;
    localparam int       NUM_SETTINGS      = 6;
    localparam cfg_idx_t CFG_PAST_LAST     = cfg_idx_t'(CFG_OUTER_Z_MAX + 2);

    logic     aclk;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    pbd_in_t  s_data    = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    pbd_out_t m_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    cfg_idx_t cfg_index = CFG_OUTER_X_MIN;
    coord_t   cfg_data  = '0;

    int       mismatches;
    int       awaited;
    int       checked;
    int       cycle_count    = 0;
    int       words_sent     = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    int       idle_send[4]   = '{0, 63, 0, 30};
    int       idle_recv[4]   = '{0, 0, 63, 30};
    pbd_box_t outer_now;
    pbd_box_t outer_settings[NUM_SETTINGS];

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    point_box_distance_squared dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    point_box_distance_squared_checker scoreboard (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .awaited    (awaited),
        .checked    (checked)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic longint clamp_coord(longint v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic pbd_in_t make_word(longint x, longint y, longint z,
                                          longint xl, longint xh, longint yl,
                                          longint yh, longint zl, longint zh,
                                          bit inner);
        pbd_in_t w;
        w.px = coord_t'(x);
        w.py = coord_t'(y);
        w.pz = coord_t'(z);
        w.box_x_min = coord_t'(xl);
        w.box_x_max = coord_t'(xh);
        w.box_y_min = coord_t'(yl);
        w.box_y_max = coord_t'(yh);
        w.box_z_min = coord_t'(zl);
        w.box_z_max = coord_t'(zh);
        w.inner_only = inner;
        return w;
    endfunction

    function automatic pbd_box_t make_box(longint xl, longint xh, longint yl,
                                          longint yh, longint zl, longint zh);
        pbd_box_t b;
        b.x_min = coord_t'(xl);
        b.x_max = coord_t'(xh);
        b.y_min = coord_t'(yl);
        b.y_max = coord_t'(yh);
        b.z_min = coord_t'(zl);
        b.z_max = coord_t'(zh);
        return b;
    endfunction

    // Mostly well-formed boxes, often sharing faces with the outer bounds,
    // with the point inside, on a face, just outside or anywhere
    function automatic pbd_in_t random_query(pbd_box_t ob);
        logic [223:0] noise;
        longint       lo[3], hi[3], pt[3], olo[3], ohi[3];
        longint       c, e;
        int           kind, stick_pct, a;
        pbd_in_t      w;
        kind = $urandom_range(9);
        if (kind < 2) begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            return noise[$bits(pbd_in_t)-1:0];
        end
        olo[0] = ob.x_min;  olo[1] = ob.y_min;  olo[2] = ob.z_min;
        ohi[0] = ob.x_max;  ohi[1] = ob.y_max;  ohi[2] = ob.z_max;
        stick_pct = (kind >= 8) ? 85 : 20;
        for (a = 0; a < 3; a++) begin
            c = coord_t'($urandom);
            e = ($urandom_range(3) == 0) ? $urandom_range(1 << 22) : $urandom_range(12);
            lo[a] = clamp_coord(c - e);
            hi[a] = clamp_coord(c + e + $urandom_range(2));
            if ($urandom_range(99) < stick_pct)
                lo[a] = olo[a];
            if ($urandom_range(99) < stick_pct)
                hi[a] = ohi[a];
            case ((kind >= 8) ? 0 : $urandom_range(5))
                0, 1, 2: pt[a] = (hi[a] >= lo[a]) ? lo[a] + $urandom_range(hi[a] - lo[a])
                                                  : lo[a];
                3:       pt[a] = $urandom_range(1) ? hi[a] : lo[a];
                4:       pt[a] = $urandom_range(1) ? clamp_coord(hi[a] + $urandom_range(1, 20))
                                                   : clamp_coord(lo[a] - $urandom_range(1, 20));
                default: pt[a] = coord_t'($urandom);
            endcase
        end
        w = make_word(pt[0], pt[1], pt[2], lo[0], hi[0], lo[1], hi[1], lo[2], hi[2],
                      (kind >= 8) ? 1'b1 : 1'($urandom_range(1)));
        return w;
    endfunction

    // Leaves valid high on return so back-to-back words need no extra edge
    task automatic push_word(pbd_in_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        words_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (awaited != 0)
            @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, coord_t v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    task automatic set_outer(pbd_box_t b, bit poke_unmapped);
        write_reg(CFG_OUTER_X_MIN, b.x_min);
        write_reg(CFG_OUTER_X_MAX, b.x_max);
        write_reg(CFG_OUTER_Y_MIN, b.y_min);
        write_reg(CFG_OUTER_Y_MAX, b.y_max);
        write_reg(CFG_OUTER_Z_MIN, b.z_min);
        write_reg(CFG_OUTER_Z_MAX, b.z_max);
        // An index past the last register must be dropped
        if (poke_unmapped)
            write_reg(CFG_PAST_LAST, coord_t'($urandom));
        cfg_valid <= 1'b0;
        outer_now = b;
        @(posedge aclk);
    endtask

    initial begin
        outer_now = make_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        outer_settings[0] = make_box(-1000, 1000, -1000, 1000, -1000, 1000);
        outer_settings[1] = make_box(0, 0, 0, 0, 0, 0);
        outer_settings[2] = make_box(coord_t'($urandom), coord_t'($urandom),
                                     coord_t'($urandom), coord_t'($urandom),
                                     coord_t'($urandom), coord_t'($urandom));
        outer_settings[3] = make_box(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                                     COORD_MAX, COORD_MIN);
        outer_settings[4] = make_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                                     COORD_MIN, COORD_MAX);
        outer_settings[5] = make_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, -1, 0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words under the reset outer bounds, no idling
        push_word(make_word(0, 0, 0, -10, 10, -10, 10, -10, 10, 0));
        push_word(make_word(3, 0, 0, -10, 10, -10, 10, -10, 10, 0));
        push_word(make_word(0, -8, 0, -10, 10, -10, 10, -10, 10, 0));
        push_word(make_word(0, 8, 0, -10, 10, -10, 10, -10, 10, 0));
        push_word(make_word(0, 0, -9, -10, 10, -10, 10, -10, 10, 0));
        push_word(make_word(0, 0, 9, -10, 10, -10, 10, -10, 10, 0));
        push_word(make_word(10, 0, 0, -10, 10, -10, 10, -10, 10, 0));
        push_word(make_word(20, 0, 0, -10, 10, -10, 10, -10, 10, 0));
        push_word(make_word(20, 20, 0, -10, 10, -10, 10, -10, 10, 0));
        push_word(make_word(-20, -20, -20, -10, 10, -10, 10, -10, 10, 0));
        push_word(make_word(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                            COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0));
        push_word(make_word(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                            COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1));
        push_word(make_word(0, 0, 0, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                            COORD_MIN, COORD_MAX, 1));
        push_word(make_word(0, 0, 0, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                            COORD_MIN, COORD_MAX, 0));
        push_word(make_word(20, 0, 0, -10, 10, -10, 10, -10, 10, 1));
        push_word(make_word(0, 0, 0, COORD_MIN, COORD_MAX, -10, 10, -10, 10, 1));
        push_word(make_word(0, 0, 0, 10, -10, -10, 10, -10, 10, 0));
        push_word(make_word(20, 0, 0, 10, -10, -10, 10, -10, 10, 0));
        push_word(make_word(0, 0, 0, 10, -10, 10, -10, 10, -10, 1));
        push_word(make_word(COORD_MIN, COORD_MAX, 0, COORD_MIN, COORD_MAX, COORD_MIN,
                            COORD_MAX, COORD_MIN, COORD_MAX, 0));
        push_word(make_word(COORD_MIN, COORD_MAX, 0, COORD_MIN, COORD_MAX, COORD_MIN,
                            COORD_MAX, COORD_MIN, COORD_MAX, 1));
        push_word(make_word(5, -5, 7, 5, 5, -5, -5, 7, 7, 1));

        for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
            drain_results();
            repeat (6) @(posedge aclk);
            set_outer(outer_settings[ph], ph == 4);
            send_idle_pct = idle_send[ph % 4];
            recv_stall_pct = idle_recv[ph % 4];
            for (int k = 0; k < WORDS_PER_SETTING; k++) begin
                // Hold off mid-phase until the pipeline runs dry
                if (ph == 2 && k == WORDS_PER_SETTING / 2)
                    drain_results();
                push_word(random_query(outer_now));
            end
        end

        drain_results();
        recv_stall_pct = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        $display("Sent %0d query words over %0d outer-bound settings: faces, edges, corners,",
                 words_sent, NUM_SETTINGS + 1);
        $display("inside ties, inner-only skips and inverted boxes; %0d results checked.",
                 checked);
        if (mismatches == 0 && awaited == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
